FILE: hw/rtl/msitt_pkg.sv
`default_nettype none
package msitt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int TIME_BITS = 32;
   localparam int RUN_BITS = 16;

   // operation codes
   localparam logic [3:0] FUNC_TICK    = 4'd0;
   localparam logic [3:0] FUNC_ALLOC   = 4'd1;
   localparam logic [3:0] FUNC_CHANGE  = 4'd2;
   localparam logic [3:0] FUNC_DELETE  = 4'd3;
   localparam logic [3:0] FUNC_RESTART = 4'd4;
   localparam logic [3:0] FUNC_ENABLE  = 4'd5;
   localparam logic [3:0] FUNC_DISABLE = 4'd6;
   localparam logic [3:0] FUNC_TOGGLE  = 4'd7;
   localparam logic [3:0] FUNC_ENA_ALL = 4'd8;
   localparam logic [3:0] FUNC_DIS_ALL = 4'd9;
   localparam logic [3:0] FUNC_QUERY   = 4'd10;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] now_ms;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic [15:0] run_limit;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] slot_id;
      logic       fired;
      logic       freed;
      logic       ok;
      logic       slot_enabled;
      logic       slot_used;
      logic [4:0] used_count;
      logic       last;
   } rsp_type;

   // one timer entry as held in the slot memory
   typedef struct packed {
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] start;
      logic [RUN_BITS-1:0]  limit;
      logic [RUN_BITS-1:0]  runs;
   } entry_type;

endpackage
`default_nettype wire

FILE: hw/rtl/msitt_rem.sv
`default_nettype none
// Bit-serial restoring remainder: one dividend bit per cycle.
module msitt_rem (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [msitt_pkg::TIME_BITS-1:0] dividend,
   input  wire logic [msitt_pkg::TIME_BITS-1:0] divisor,
   output logic                                 done,
   output logic [msitt_pkg::TIME_BITS-1:0]      rem
);
   localparam int T = msitt_pkg::TIME_BITS;
   localparam int CNTW = $clog2(T + 1);

   logic [CNTW-1:0] cnt_ff;
   logic            run_ff;
   logic            done_ff;
   logic [T:0]      rem_ff;
   logic [T-1:0]    dvd_ff;
   logic [T-1:0]    dvs_ff;
   logic [T:0]      trial;

   assign trial = {rem_ff[T-1:0], dvd_ff[T-1]};

   // shift in one bit, subtract when it fits
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNTW'(T);
            rem_ff <= '0;
            dvd_ff <= dividend;
            dvs_ff <= divisor;
         end else if (run_ff) begin
            dvd_ff <= {dvd_ff[T-2:0], 1'b0};
            if (trial >= {1'b0, dvs_ff}) begin
               rem_ff <= trial - {1'b0, dvs_ff};
            end else begin
               rem_ff <= trial;
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff[T-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/multi_slot_interval_timer_table.sv
// Operations other than tick pass S_OP and S_REPLY to the single reply word;
// change period on a used slot and restart on a slot in range also pass S_OPWB,
// which read-modify-writes the slot memory. Tick: a scan of all slots loads
// each used one and updates zero-period and due ones (due ones via the divider),
// then walks the slots up to the last firing one. busy stays high until done.
// Reports strobe once and cannot be stalled; reset frees slots, memory uncleared.
`default_nettype none
module multi_slot_interval_timer_table #(
   parameter int SLOTS = msitt_pkg::SLOTS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire msitt_pkg::req_type req_word,
   output logic                    rsp_valid,
   output msitt_pkg::rsp_type      rsp_word
);
   localparam int T = msitt_pkg::TIME_BITS;
   localparam int R = msitt_pkg::RUN_BITS;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IW = $clog2(SLOTS + 1);
   localparam int CW = $clog2(SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_TSCAN, S_TLOAD, S_TDIV, S_TUPD, S_TEMIT, S_OP, S_OPWB, S_REPLY
   } state_type;

   state_type           state_ff;
   msitt_pkg::req_type  req_ff;
   logic [IW-1:0]       idx_ff;
   logic [SLOTS-1:0]    used_ff;
   logic [SLOTS-1:0]    on_ff;
   logic [SLOTS-1:0]    lim0_ff;
   logic [SLOTS-1:0]    fire_ff;
   logic [SLOTS-1:0]    del_ff;
   logic [CW-1:0]       count_ff;
   logic                alloc_ok_ff;
   logic [SW-1:0]       alloc_id_ff;
   msitt_pkg::entry_type ent_ff;
   logic [T-1:0]        diff_ff;
   msitt_pkg::rsp_type  rsp_ff;
   logic                rsp_valid_ff;

   msitt_pkg::entry_type mem [SLOTS];
   msitt_pkg::entry_type rd_ff;
   msitt_pkg::entry_type wr_data;
   msitt_pkg::entry_type clear_ent;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr;
   logic [SW-1:0]        rd_addr;

   logic [SW-1:0] idx_sel;
   logic [SW-1:0] slot_sel;
   logic          slot_ok;
   logic [T-1:0]  diff;
   logic          free_found;
   logic [SW-1:0] free_idx;
   logic          fire;
   logic          del;
   logic [R-1:0]  runs_n;
   logic          lim_zero;
   logic [SLOTS-1:0] hi_mask;
   logic          div_start;
   logic          div_done;
   logic [T-1:0]  div_rem;

   assign idx_sel  = idx_ff[SW-1:0];
   assign slot_sel = SW'(req_ff.slot);
   assign slot_ok  = (int'(req_ff.slot) < SLOTS);
   assign diff     = req_ff.now_ms[T-1:0] - rd_ff.start;
   assign clear_ent = '{period: '0, start: req_ff.now_ms[T-1:0], limit: '0, runs: '0};

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (!used_ff[j]) begin
            free_found = 1'b1;
            free_idx   = SW'(j);
         end
      end
   end

   // run accounting of the slot under update
   always_comb begin
      lim_zero = (ent_ff.limit == '0);
      fire     = on_ff[idx_sel] && (lim_zero || (ent_ff.runs < ent_ff.limit));
      runs_n   = (fire && !lim_zero) ? ent_ff.runs + 1'b1 : ent_ff.runs;
      del      = fire && !lim_zero && (runs_n >= ent_ff.limit);
   end

   // slots above the emit pointer
   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         hi_mask[j] = (IW'(j) > idx_ff);
      end
   end

   assign div_start = (state_ff == S_TLOAD) && (rd_ff.period != '0) && (diff >= rd_ff.period);

   msitt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (rd_ff.period),
      .done     (div_done),
      .rem      (div_rem)
   );

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_sel;
      wr_data = clear_ent;
      rd_addr = (state_ff == S_TSCAN) ? idx_sel : slot_sel;
      unique case (state_ff)
         S_TUPD: begin
            wr_en   = 1'b1;
            wr_addr = idx_sel;
            wr_data = del ? clear_ent : '{period: ent_ff.period, start: ent_ff.start,
                                          limit: ent_ff.limit, runs: runs_n};
         end
         S_OP: begin
            if (req_ff.func == msitt_pkg::FUNC_ALLOC) begin
               wr_en   = free_found;
               wr_addr = free_idx;
               wr_data = '{period: req_ff.period_ms[T-1:0], start: req_ff.now_ms[T-1:0],
                           limit: req_ff.run_limit[R-1:0], runs: '0};
            end else if (req_ff.func == msitt_pkg::FUNC_DELETE) begin
               wr_en = slot_ok && used_ff[slot_sel];
            end
         end
         S_OPWB: begin
            wr_en   = 1'b1;
            wr_data = rd_ff;
            wr_data.start = req_ff.now_ms[T-1:0];
            if (req_ff.func == msitt_pkg::FUNC_CHANGE) begin
               wr_data.period = req_ff.period_ms[T-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         on_ff        <= '0;
         lim0_ff      <= '1;
         fire_ff      <= '0;
         del_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         alloc_ok_ff  <= 1'b0;
         alloc_id_ff  <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_word;
                  idx_ff <= '0;
                  if (req_word.func == msitt_pkg::FUNC_TICK) begin
                     fire_ff  <= '0;
                     del_ff   <= '0;
                     state_ff <= S_TSCAN;
                  end else begin
                     state_ff <= S_OP;
                  end
               end
            end
            S_TSCAN: begin
               if (idx_ff == IW'(SLOTS)) begin
                  idx_ff   <= '0;
                  state_ff <= S_TEMIT;
               end else if (!used_ff[idx_sel]) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= S_TLOAD;
               end
            end
            S_TLOAD: begin
               diff_ff <= diff;
               if (rd_ff.period == '0) begin
                  ent_ff   <= '{period: rd_ff.period, start: req_ff.now_ms[T-1:0],
                                limit: rd_ff.limit, runs: rd_ff.runs};
                  state_ff <= S_TUPD;
               end else if (diff >= rd_ff.period) begin
                  ent_ff   <= rd_ff;
                  state_ff <= S_TDIV;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_TSCAN;
               end
            end
            S_TDIV: begin
               if (div_done) begin
                  ent_ff.start <= ent_ff.start + (diff_ff - div_rem);
                  state_ff     <= S_TUPD;
               end
            end
            S_TUPD: begin
               fire_ff[idx_sel] <= fire;
               del_ff[idx_sel]  <= del;
               if (del) begin
                  used_ff[idx_sel] <= 1'b0;
                  on_ff[idx_sel]   <= 1'b0;
                  lim0_ff[idx_sel] <= 1'b1;
                  count_ff         <= count_ff - 1'b1;
               end
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_TSCAN;
            end
            S_TEMIT: begin
               rsp_ff.kind       <= msitt_pkg::KIND_TICK;
               rsp_ff.used_count <= 5'(count_ff);
               if (fire_ff == '0) begin
                  rsp_ff.slot_id      <= '0;
                  rsp_ff.fired        <= 1'b0;
                  rsp_ff.freed        <= 1'b0;
                  rsp_ff.ok           <= 1'b0;
                  rsp_ff.slot_enabled <= 1'b0;
                  rsp_ff.slot_used    <= 1'b0;
                  rsp_ff.last         <= 1'b1;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end else begin
                  if (fire_ff[idx_sel]) begin
                     rsp_ff.slot_id      <= 4'(idx_sel);
                     rsp_ff.fired        <= 1'b1;
                     rsp_ff.freed        <= del_ff[idx_sel];
                     rsp_ff.ok           <= 1'b1;
                     rsp_ff.slot_enabled <= 1'b1;
                     rsp_ff.slot_used    <= !del_ff[idx_sel];
                     rsp_ff.last         <= ((fire_ff & hi_mask) == '0);
                     rsp_valid_ff        <= 1'b1;
                     if ((fire_ff & hi_mask) == '0) begin
                        state_ff <= S_IDLE;
                     end
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_OP: begin
               state_ff <= S_REPLY;
               priority case (req_ff.func)
                  msitt_pkg::FUNC_ALLOC: begin
                     alloc_ok_ff <= free_found;
                     alloc_id_ff <= free_idx;
                     if (free_found) begin
                        used_ff[free_idx] <= 1'b1;
                        on_ff[free_idx]   <= 1'b1;
                        lim0_ff[free_idx] <= (req_ff.run_limit[R-1:0] == '0);
                        count_ff          <= count_ff + 1'b1;
                     end
                  end
                  msitt_pkg::FUNC_ENA_ALL: on_ff <= on_ff | (used_ff & lim0_ff);
                  msitt_pkg::FUNC_DIS_ALL: on_ff <= on_ff & ~(used_ff & lim0_ff);
                  default: begin
                     if (slot_ok) begin
                        priority case (req_ff.func)
                           msitt_pkg::FUNC_CHANGE: begin
                              if (used_ff[slot_sel]) begin
                                 state_ff <= S_OPWB;
                              end
                           end
                           msitt_pkg::FUNC_DELETE: begin
                              if (used_ff[slot_sel]) begin
                                 used_ff[slot_sel] <= 1'b0;
                                 on_ff[slot_sel]   <= 1'b0;
                                 lim0_ff[slot_sel] <= 1'b1;
                                 count_ff          <= count_ff - 1'b1;
                              end
                           end
                           msitt_pkg::FUNC_RESTART: state_ff <= S_OPWB;
                           msitt_pkg::FUNC_ENABLE:  on_ff[slot_sel] <= 1'b1;
                           msitt_pkg::FUNC_DISABLE: on_ff[slot_sel] <= 1'b0;
                           msitt_pkg::FUNC_TOGGLE:  on_ff[slot_sel] <= !on_ff[slot_sel];
                           default: begin
                           end
                        endcase
                     end
                  end
               endcase
            end
            S_OPWB: begin
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               rsp_ff.kind       <= msitt_pkg::KIND_REPLY;
               rsp_ff.fired      <= 1'b0;
               rsp_ff.freed      <= 1'b0;
               rsp_ff.used_count <= 5'(count_ff);
               rsp_ff.last       <= 1'b1;
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_IDLE;
               if (req_ff.func == msitt_pkg::FUNC_ALLOC) begin
                  rsp_ff.slot_id      <= alloc_ok_ff ? 4'(alloc_id_ff) : 4'd0;
                  rsp_ff.ok           <= alloc_ok_ff;
                  rsp_ff.slot_enabled <= alloc_ok_ff;
                  rsp_ff.slot_used    <= alloc_ok_ff;
               end else if (req_ff.func == msitt_pkg::FUNC_ENA_ALL ||
                            req_ff.func == msitt_pkg::FUNC_DIS_ALL) begin
                  rsp_ff.slot_id      <= '0;
                  rsp_ff.ok           <= 1'b1;
                  rsp_ff.slot_enabled <= 1'b0;
                  rsp_ff.slot_used    <= 1'b0;
               end else if (req_ff.func <= msitt_pkg::FUNC_QUERY) begin
                  rsp_ff.slot_id      <= req_ff.slot;
                  rsp_ff.ok           <= slot_ok && used_ff[slot_sel];
                  rsp_ff.slot_enabled <= slot_ok && on_ff[slot_sel];
                  rsp_ff.slot_used    <= slot_ok && used_ff[slot_sel];
               end else begin
                  rsp_ff.slot_id      <= '0;
                  rsp_ff.ok           <= 1'b0;
                  rsp_ff.slot_enabled <= 1'b0;
                  rsp_ff.slot_used    <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/msitt_checker.sv
`default_nettype none
module msitt_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire msitt_pkg::rsp_type rsp_word
);
   // an accepted word keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");

   // nothing follows the final word of an item
   a_last_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |=> !rsp_valid) else $error("word after last");

   // operation replies are single words
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind |-> rsp_word.last) else $error("reply without last");

   // a freed slot fired and is no longer used
   a_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.freed |-> rsp_word.fired && !rsp_word.slot_used && !rsp_word.kind)
      else $error("inconsistent freed report");
endmodule

bind multi_slot_interval_timer_table msitt_checker u_msitt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
`default_nettype wire
